@@ design/qadd_pkg.sv @@
// shared types and constants for the quantized byte vector add
package qadd_pkg;

  localparam int MAX_LANES = 8;
  localparam int DEF_LANES = 8;
  localparam int BYTE_W = 8;
  localparam int VEC_W = MAX_LANES * BYTE_W;
  localparam int CNT_W = 4;
  localparam int LANE_STAGES = 5;
  localparam int LATENCY = LANE_STAGES + 1;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ACC_BIAS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_MULTIPLIER = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_MULTIPLIER = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_LIMIT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_OFFSET = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 4'd7;

  typedef struct packed {
    logic [31:0] acc_bias;
    logic [31:0] a_multiplier;
    logic [31:0] b_multiplier;
    logic [4:0]  shift;
    logic [30:0] round_limit;
    logic [7:0]  out_offset;
    logic [7:0]  y_min;
    logic [7:0]  y_max;
  } qadd_cfg_t;

  localparam qadd_cfg_t CFG_RESET = '{
    acc_bias: 32'd0,
    a_multiplier: 32'd0,
    b_multiplier: 32'd0,
    shift: 5'd0,
    round_limit: 31'd0,
    out_offset: 8'd0,
    y_min: 8'd0,
    y_max: 8'd255
  };

endpackage

@@ design/qadd_lane.sv @@
// one lane: scale, bias, rounding shift, saturation and clamp
module qadd_lane
  import qadd_pkg::*;
(
  input  logic              clk,
  input  qadd_cfg_t         cfg,
  input  logic [BYTE_W-1:0] a_i,
  input  logic [BYTE_W-1:0] b_i,
  output logic [BYTE_W-1:0] y_o
);

  logic [31:0] pa_r, pb_r, pa_nxt, pb_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] sh_r, sh_nxt;
  logic        rnd_r, rnd_nxt;
  logic signed [15:0] v16_r, v16_nxt;
  logic [BYTE_W-1:0]  y_r, y_nxt;

  logic [31:0] mask;
  logic signed [32:0] rem;
  logic signed [31:0] q;
  logic signed [16:0] sum;
  logic [7:0] clip;
  logic [7:0] lo;

  // stage 1: products mod 2^32
  assign pa_nxt = 32'(40'(a_i) * 40'(cfg.a_multiplier));
  assign pb_nxt = 32'(40'(b_i) * 40'(cfg.b_multiplier));

  // stage 2: accumulate
  assign acc_nxt = cfg.acc_bias + pa_r + pb_r;

  // stage 3: arithmetic shift and round decision
  always_comb begin
    mask = (32'd1 << cfg.shift) - 32'd1;
    rem = $signed({1'b0, acc_r & mask}) - $signed({32'd0, acc_r[31]});
    rnd_nxt = rem > $signed({2'b00, cfg.round_limit});
    sh_nxt = 32'($signed(acc_r) >>> cfg.shift);
  end

  // stage 4: round up and saturate to int16
  always_comb begin
    q = $signed(sh_r + {31'd0, rnd_r});
    if (q > 32'sd32767) begin
      v16_nxt = 16'sh7fff;
    end else if (q < -32'sd32768) begin
      v16_nxt = -16'sh8000;
    end else begin
      v16_nxt = q[15:0];
    end
  end

  // stage 5: zero point, uint8 saturation, clamp
  always_comb begin
    sum = $signed({v16_r[15], v16_r}) + $signed({9'd0, cfg.out_offset});
    if (sum < 17'sd0) begin
      clip = 8'd0;
    end else if (sum > 17'sd255) begin
      clip = 8'd255;
    end else begin
      clip = sum[7:0];
    end
    lo = (clip < cfg.y_min) ? cfg.y_min : clip;
    y_nxt = (lo > cfg.y_max) ? cfg.y_max : lo;
  end

  always_ff @(posedge clk) begin
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    rnd_r <= rnd_nxt;
    v16_r <= v16_nxt;
    y_r   <= y_nxt;
  end

  assign y_o = y_r;

endmodule

@@ design/qadd_merge.sv @@
// merging stage: blanks lanes past the count and registers the result
module qadd_merge
  import qadd_pkg::*;
(
  input  logic                               clk,
  input  logic [MAX_LANES-1:0][BYTE_W-1:0]   lane_y_i,
  input  logic [CNT_W-1:0]                   count_i,
  output logic [VEC_W-1:0]                   y_bytes_o,
  output logic [CNT_W-1:0]                   lanes_o
);

  logic [VEC_W-1:0] y_r, y_nxt;
  logic [CNT_W-1:0] lanes_r;

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      y_nxt[i*BYTE_W +: BYTE_W] = (CNT_W'(i) < count_i) ? lane_y_i[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    y_r     <= y_nxt;
    lanes_r <= count_i;
  end

  assign y_bytes_o = y_r;
  assign lanes_o = lanes_r;

endmodule

@@ design/quantized_u8_vector_add_unit.sv @@
// top level of the quantized unsigned byte vector add
//
// Takes one item of up to eight byte pairs in every clock cycle and returns
// its result on out_valid after five register stages per lane (products,
// accumulate, rounding shift, int16 saturation, zero point and clamp) plus
// one merging register that zeroes lanes past the count. busy stays low, so
// items may be issued back to back; the receiver must take each result in
// the cycle it is shown. Counts above the lane limit are saturated.
// Configuration writes are always ready and must only be made while no item
// is in flight.
module quantized_u8_vector_add_unit
  import qadd_pkg::*;
#(
  parameter int LANES = DEF_LANES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VEC_W-1:0]      in_a_bytes,
  input  logic [VEC_W-1:0]      in_b_bytes,
  input  logic [CNT_W-1:0]      in_valid_count,
  output logic                  out_valid,
  output logic [VEC_W-1:0]      out_y_bytes,
  output logic [CNT_W-1:0]      out_valid_lanes,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ACT_LANES = (LANES > MAX_LANES) ? MAX_LANES : LANES;

  qadd_cfg_t cfg_r, cfg_nxt;
  logic [LATENCY-1:0] vld_r, vld_nxt;
  logic [LANE_STAGES-1:0][CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_sat;
  logic [MAX_LANES-1:0][BYTE_W-1:0] lane_y;
  logic accept;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ACC_BIAS:     cfg_nxt.acc_bias = cfg_data;
        REG_A_MULTIPLIER: cfg_nxt.a_multiplier = cfg_data;
        REG_B_MULTIPLIER: cfg_nxt.b_multiplier = cfg_data;
        REG_SHIFT:        cfg_nxt.shift = cfg_data[4:0];
        REG_ROUND_LIMIT:  cfg_nxt.round_limit = cfg_data[30:0];
        REG_OUT_OFFSET:   cfg_nxt.out_offset = cfg_data[7:0];
        REG_Y_MIN:        cfg_nxt.y_min = cfg_data[7:0];
        REG_Y_MAX:        cfg_nxt.y_max = cfg_data[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  assign vld_nxt = {vld_r[LATENCY-2:0], accept};
  assign cnt_sat = (in_valid_count > CNT_W'(ACT_LANES)) ? CNT_W'(ACT_LANES) : in_valid_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
      vld_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      vld_r <= vld_nxt;
    end
  end

  // count travels alongside the lane pipeline
  always_ff @(posedge clk) begin
    cnt_r <= {cnt_r[LANE_STAGES-2:0], cnt_sat};
  end

  for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
    if (i < ACT_LANES) begin : g_on
      qadd_lane u_lane (
        .clk (clk),
        .cfg (cfg_r),
        .a_i (in_a_bytes[i*BYTE_W +: BYTE_W]),
        .b_i (in_b_bytes[i*BYTE_W +: BYTE_W]),
        .y_o (lane_y[i])
      );
    end else begin : g_off
      assign lane_y[i] = '0;
    end
  end

  qadd_merge u_merge (
    .clk       (clk),
    .lane_y_i  (lane_y),
    .count_i   (cnt_r[LANE_STAGES-1]),
    .y_bytes_o (out_y_bytes),
    .lanes_o   (out_valid_lanes)
  );

  assign out_valid = vld_r[LATENCY-1];

endmodule

@@ design/qadd_checker.sv @@
// port-level checks for the quantized byte vector add, bound to the top level
module qadd_checker
  import qadd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [VEC_W-1:0] out_y_bytes,
  input logic [CNT_W-1:0] out_valid_lanes
);

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted item not returned after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  a_lanes_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_lanes <= CNT_W'(MAX_LANES)))
    else $error("lane count above limit");

  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_valid_lanes == '0) |-> (out_y_bytes == '0))
    else $error("empty item carries nonzero bytes");

endmodule

bind quantized_u8_vector_add_unit qadd_checker u_qadd_checker (.*);

@@ dv/quantized_u8_vector_add_unit_tb.sv @@
// self-checking testbench for the quantized unsigned byte vector add unit
`timescale 1ns / 100ps

module quantized_u8_vector_add_unit_tb;
  import qadd_pkg::*;

  localparam int LANES_TB = DEF_LANES;
  localparam int LANE_LIMIT = (LANES_TB > MAX_LANES) ? MAX_LANES : LANES_TB;
  localparam int RAND_ITEMS = 2000;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = RAND_ITEMS / NUM_PHASES;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum int {CFG_TYPICAL, CFG_WILD, CFG_EXTREME} cfg_mode_t;

  typedef struct {
    row_kind_t        kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [VEC_W-1:0] a;
    logic [VEC_W-1:0] b;
    logic [CNT_W-1:0] cnt;
    bit               typed;
    logic [VEC_W-1:0] y;
    logic [CNT_W-1:0] lanes;
  } stim_row_t;

  typedef struct {
    logic [VEC_W-1:0] y;
    logic [CNT_W-1:0] lanes;
  } sum_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [VEC_W-1:0] in_a_bytes = '0;
  logic [VEC_W-1:0] in_b_bytes = '0;
  logic [CNT_W-1:0] in_valid_count = '0;
  logic out_valid;
  logic [VEC_W-1:0] out_y_bytes;
  logic [CNT_W-1:0] out_valid_lanes;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  qadd_cfg_t   cfg_shadow;
  sum_result_t sum_q[$];
  sum_result_t sum_head;
  stim_row_t   directed_rows[$];

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int odd_counts = 0;

  quantized_u8_vector_add_unit #(.LANES(LANES_TB)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_a_bytes     (in_a_bytes),
    .in_b_bytes     (in_b_bytes),
    .in_valid_count (in_valid_count),
    .out_valid      (out_valid),
    .out_y_bytes    (out_y_bytes),
    .out_valid_lanes(out_valid_lanes),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] requant_lane(logic [7:0] a, logic [7:0] b, qadd_cfg_t c);
    logic [31:0] acc;
    logic [31:0] mask;
    logic [31:0] rem;
    logic [31:0] sh;
    int v;
    acc = c.acc_bias + {24'd0, a} * c.a_multiplier + {24'd0, b} * c.b_multiplier;
    mask = (32'd1 << c.shift) - 32'd1;
    rem = (acc & mask) - {31'd0, acc[31]};
    sh = acc[31] ? ~((~acc) >> c.shift) : (acc >> c.shift);
    if ($signed(rem) > $signed({1'b0, c.round_limit})) sh = sh + 32'd1;
    v = $signed(sh);
    v = clip(v, -32768, 32767);
    v = clip(v + int'(c.out_offset), -32768, 32767);
    v = clip(v, 0, 255);
    if (v < int'(c.y_min)) v = int'(c.y_min);
    if (v > int'(c.y_max)) v = int'(c.y_max);
    return v[7:0];
  endfunction

  function automatic sum_result_t predict_sum(logic [VEC_W-1:0] a, logic [VEC_W-1:0] b,
                                              logic [CNT_W-1:0] cnt, qadd_cfg_t c);
    sum_result_t r;
    int n;
    n = (int'(cnt) > LANE_LIMIT) ? LANE_LIMIT : int'(cnt);
    r.y = '0;
    for (int i = 0; i < n; i++) begin
      r.y[8*i +: 8] = requant_lane(a[8*i +: 8], b[8*i +: 8], c);
    end
    r.lanes = n[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [VEC_W-1:0] rand_bytes();
    logic [VEC_W-1:0] v;
    for (int i = 0; i < MAX_LANES; i++) begin
      case ($urandom_range(0, 7))
        0: v[8*i +: 8] = 8'h00;
        1: v[8*i +: 8] = 8'hff;
        default: v[8*i +: 8] = 8'($urandom);
      endcase
    end
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 4'd8;
    if (r < 90) return 4'($urandom_range(1, 7));
    if (r < 95) return 4'd0;
    return 4'($urandom_range(9, 15));
  endfunction

  function automatic void put_cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: data, a: '0, b: '0, cnt: '0, typed: 1'b0,
          y: '0, lanes: '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void put_item_row(logic [VEC_W-1:0] a, logic [VEC_W-1:0] b,
                                       logic [CNT_W-1:0] cnt, bit typed,
                                       logic [VEC_W-1:0] y, logic [CNT_W-1:0] lanes);
    stim_row_t r;
    r = '{kind: ROW_ITEM, idx: '0, data: '0, a: a, b: b, cnt: cnt, typed: typed,
          y: y, lanes: lanes};
    directed_rows.push_back(r);
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ACC_BIAS:     cfg_shadow.acc_bias = data;
      REG_A_MULTIPLIER: cfg_shadow.a_multiplier = data;
      REG_B_MULTIPLIER: cfg_shadow.b_multiplier = data;
      REG_SHIFT:        cfg_shadow.shift = data[4:0];
      REG_ROUND_LIMIT:  cfg_shadow.round_limit = data[30:0];
      REG_OUT_OFFSET:   cfg_shadow.out_offset = data[7:0];
      REG_Y_MIN:        cfg_shadow.y_min = data[7:0];
      REG_Y_MAX:        cfg_shadow.y_max = data[7:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic send_item(logic [VEC_W-1:0] a, logic [VEC_W-1:0] b, logic [CNT_W-1:0] cnt,
                           bit typed, logic [VEC_W-1:0] ty, logic [CNT_W-1:0] tl);
    sum_result_t r;
    start <= 1'b1;
    in_a_bytes <= a;
    in_b_bytes <= b;
    in_valid_count <= cnt;
    do @(posedge clk); while (busy);
    if (typed) begin
      r.y = ty;
      r.lanes = tl;
    end else begin
      r = predict_sum(a, b, cnt, cfg_shadow);
    end
    sum_q.push_back(r);
    items_sent++;
    if (cnt == 0 || int'(cnt) > LANE_LIMIT) odd_counts++;
  endtask

  task automatic idle_burst();
    int n;
    n = $urandom_range(1, 17);
    start <= 1'b0;
    repeat (n) begin
      in_a_bytes <= rand_bytes();
      @(posedge clk);
    end
  endtask

  task automatic wait_pipeline_empty();
    start <= 1'b0;
    while (sum_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic rand_config(cfg_mode_t mode);
    int s;
    int am;
    int bm;
    int zpp;
    int mask;
    int thr;
    case (mode)
      CFG_TYPICAL: begin
        s = $urandom_range(8, 22);
        am = $urandom_range(0, 1 << s);
        bm = $urandom_range(0, 1 << s);
        zpp = -128 * (am + bm) + int'($urandom_range(0, 1 << s)) - (1 << (s - 1));
        mask = (1 << s) - 1;
        case ($urandom_range(0, 2))
          0: thr = mask >> 1;
          1: thr = 0;
          default: thr = $urandom_range(0, mask);
        endcase
        cfg_write(REG_ACC_BIAS, zpp);
        cfg_write(REG_A_MULTIPLIER, am);
        cfg_write(REG_B_MULTIPLIER, bm);
        cfg_write(REG_SHIFT, s);
        cfg_write(REG_ROUND_LIMIT, thr);
        cfg_write(REG_OUT_OFFSET, $urandom_range(96, 160));
        cfg_write(REG_Y_MIN, $urandom_range(0, 1) ? 0 : $urandom_range(0, 60));
        cfg_write(REG_Y_MAX, $urandom_range(0, 1) ? 255 : $urandom_range(180, 255));
      end
      CFG_WILD: begin
        cfg_write(REG_ACC_BIAS, $urandom);
        cfg_write(REG_A_MULTIPLIER, $urandom);
        cfg_write(REG_B_MULTIPLIER, $urandom);
        cfg_write(REG_SHIFT, $urandom_range(0, 31));
        cfg_write(REG_ROUND_LIMIT, $urandom & 32'h7fff_ffff);
        cfg_write(REG_OUT_OFFSET, $urandom_range(0, 255));
        cfg_write(REG_Y_MIN, $urandom_range(0, 255));
        cfg_write(REG_Y_MAX, $urandom_range(0, 255));
      end
      default: begin
        cfg_write(REG_ACC_BIAS, $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff);
        cfg_write(REG_A_MULTIPLIER, $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff);
        cfg_write(REG_B_MULTIPLIER, $urandom_range(0, 1) ? 32'h1 : 32'hffff_ffff);
        cfg_write(REG_SHIFT, $urandom_range(0, 1) ? 0 : 31);
        cfg_write(REG_ROUND_LIMIT, $urandom_range(0, 1) ? 32'h0 : 32'h7fff_ffff);
        cfg_write(REG_OUT_OFFSET, $urandom_range(0, 1) ? 0 : 255);
        cfg_write(REG_Y_MIN, $urandom_range(0, 1) ? 0 : 255);
        cfg_write(REG_Y_MAX, $urandom_range(0, 1) ? 0 : 255);
      end
    endcase
    if ($urandom_range(0, 3) == 0) cfg_write(REG_Y_MAX + 4'($urandom_range(1, 8)), $urandom);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (sum_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: y_bytes %h valid_lanes %0d", $time, out_y_bytes,
                 out_valid_lanes);
      end else begin
        sum_head = sum_q.pop_front();
        results_checked++;
        if (out_y_bytes !== sum_head.y) begin
          errors++;
          $display("%0t: y_bytes mismatch: expected %h actual %h", $time, sum_head.y,
                   out_y_bytes);
        end
        if (out_valid_lanes !== sum_head.lanes) begin
          errors++;
          $display("%0t: valid_lanes mismatch: expected %0d actual %0d", $time,
                   sum_head.lanes, out_valid_lanes);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("quantized_u8_vector_add_unit test failed");
    $finish;
  end

  initial begin
    bit prev_cfg;
    int idle_pct;
    cfg_mode_t mode;

    cfg_shadow = CFG_RESET;

    // reset values give zero in every lane
    put_item_row('1, '1, 4'd8, 1'b1, 64'h0, 4'd8);
    put_item_row('0, '0, 4'd1, 1'b1, 64'h0, 4'd1);
    put_item_row('1, '0, 4'd0, 1'b1, 64'h0, 4'd0);
    put_item_row('0, '1, 4'd15, 1'b1, 64'h0, 4'd8);
    put_item_row('1, '1, 4'd9, 1'b1, 64'h0, 4'd8);
    // plain sum
    put_cfg_row(REG_A_MULTIPLIER, 32'd1);
    put_cfg_row(REG_B_MULTIPLIER, 32'd1);
    put_item_row('1, '1, 4'd8, 1'b1, 64'hffff_ffff_ffff_ffff, 4'd8);
    put_item_row('0, '0, 4'd8, 1'b1, 64'h0, 4'd8);
    put_item_row(64'h0102_0304_0506_0708, 64'h0807_0605_0403_0201, 4'd4, 1'b0, '0, '0);
    put_item_row(64'h7f80_81fe_0140_c03f, 64'h8180_7f02_ff40_40c1, 4'd3, 1'b0, '0, '0);
    // inverted clamp
    put_cfg_row(REG_Y_MIN, 32'd200);
    put_cfg_row(REG_Y_MAX, 32'd100);
    put_item_row('0, '0, 4'd8, 1'b1, 64'h6464_6464_6464_6464, 4'd8);
    put_item_row('1, '1, 4'd2, 1'b1, 64'h6464, 4'd2);
    // most negative bias, widest shift
    put_cfg_row(REG_Y_MIN, 32'd0);
    put_cfg_row(REG_Y_MAX, 32'd255);
    put_cfg_row(REG_ACC_BIAS, 32'h8000_0000);
    put_cfg_row(REG_SHIFT, 32'd31);
    put_item_row('0, '0, 4'd8, 1'b0, '0, '0);
    put_item_row('1, '1, 4'd8, 1'b0, '0, '0);
    // largest multipliers and bias, no shift
    put_cfg_row(REG_ACC_BIAS, 32'h7fff_ffff);
    put_cfg_row(REG_A_MULTIPLIER, 32'hffff_ffff);
    put_cfg_row(REG_B_MULTIPLIER, 32'hffff_ffff);
    put_cfg_row(REG_SHIFT, 32'd0);
    put_item_row('1, '1, 4'd8, 1'b0, '0, '0);
    put_item_row(64'h00ff_00ff_00ff_00ff, 64'hff00_ff00_ff00_ff00, 4'd7, 1'b0, '0, '0);
    // rounding of odd values with the top zero point
    put_cfg_row(REG_ACC_BIAS, 32'd0);
    put_cfg_row(REG_A_MULTIPLIER, 32'd1);
    put_cfg_row(REG_B_MULTIPLIER, 32'd0);
    put_cfg_row(REG_SHIFT, 32'd1);
    put_cfg_row(REG_OUT_OFFSET, 32'd255);
    put_item_row(64'h0001_0203_0405_0607, '1, 4'd8, 1'b0, '0, '0);
    // negative accumulator rounding
    put_cfg_row(REG_ACC_BIAS, 32'hffff_fffd);
    put_cfg_row(REG_SHIFT, 32'd2);
    put_cfg_row(REG_ROUND_LIMIT, 32'd1);
    put_cfg_row(REG_OUT_OFFSET, 32'd0);
    put_item_row(64'h0706_0504_0302_0100, '0, 4'd8, 1'b0, '0, '0);
    // threshold at its top never rounds
    put_cfg_row(REG_ROUND_LIMIT, 32'h7fff_ffff);
    put_cfg_row(REG_A_MULTIPLIER, 32'd16);
    put_cfg_row(REG_SHIFT, 32'd4);
    put_item_row(64'h13f7_2a80_0bcd_5e91, 64'h6c02_ee19_a4b3_0d77, 4'd6, 1'b0, '0, '0);
    // int16 saturation before and after the zero point
    put_cfg_row(REG_A_MULTIPLIER, 32'h0010_0000);
    put_cfg_row(REG_SHIFT, 32'd0);
    put_cfg_row(REG_OUT_OFFSET, 32'd255);
    put_item_row('1, '0, 4'd8, 1'b0, '0, '0);
    // writes past the last register are dropped
    put_cfg_row(REG_Y_MAX + 4'd2, 32'hffff_ffff);
    put_cfg_row(REG_Y_MAX + 4'd8, 32'h0);
    put_item_row(64'h0102_0304_0506_0708, 64'hfffe_fdfc_fbfa_f9f8, 4'd5, 1'b0, '0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    prev_cfg = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (!prev_cfg) wait_pipeline_empty();
        cfg_write(directed_rows[i].idx, directed_rows[i].data);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_valid <= 1'b0;
        send_item(directed_rows[i].a, directed_rows[i].b, directed_rows[i].cnt,
                  directed_rows[i].typed, directed_rows[i].y, directed_rows[i].lanes);
        prev_cfg = 1'b0;
        if ($urandom_range(0, 3) == 0) idle_burst();
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_pipeline_empty();
      case (p % 4)
        1: mode = CFG_WILD;
        3: mode = CFG_EXTREME;
        default: mode = CFG_TYPICAL;
      endcase
      if (p == NUM_PHASES - 1) mode = CFG_TYPICAL;
      rand_config(mode);
      cfg_valid <= 1'b0;
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 50;
      endcase
      if (p == NUM_PHASES - 1) idle_pct = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_item(rand_bytes(), rand_bytes(), rand_count(), 1'b0, '0, '0);
        if (int'($urandom_range(0, 99)) < idle_pct) idle_burst();
      end
    end

    start <= 1'b0;
    while (sum_q.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);

    $display("covered %0d items (%0d with zero or oversized counts), %0d results checked",
             items_sent, odd_counts, results_checked);
    $display("made %0d register writes over %0d random settings and the directed ones",
             cfg_writes, NUM_PHASES);
    if (errors == 0) begin
      $display("quantized_u8_vector_add_unit test passed");
    end else begin
      $display("quantized_u8_vector_add_unit test failed");
    end
    $finish;
  end

endmodule
